[hdl/svc_pkg.sv]
package svc_pkg;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  localparam int unsigned MAX_BYTES = 5;

  localparam logic [7:0] CONT_FLAG = 8'h80;
  localparam logic [7:0] SIGN_FLAG = 8'h40;

  localparam logic [31:0] EXT_MASK_1 = 32'hffffffe0;
  localparam logic [31:0] EXT_MASK_2 = 32'hfffff000;
  localparam logic [31:0] EXT_MASK_3 = 32'hfff80000;
  localparam logic [31:0] EXT_MASK_4 = 32'hfc000000;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] data_in;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         code_byte;
    logic signed [31:0] decoded_value;
    logic [2:0]         byte_count;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic [2:0] byte_count;
    logic       last;
  } enc_res_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
    logic [2:0]         byte_count;
  } dec_res_t;

endpackage

[hdl/signed_varint_codec.sv]
// Channel | Direction | Handshake               | Payload
// input   | in        | in_valid_i / in_ready_o | in_data_i  (svc_pkg::in_t)
// result  | out       | out_valid_o / out_ready_i | out_data_o (svc_pkg::out_t)
//
// An accepted beat sits in the input register; a decode byte leaves it when
// it is stepped, an encode after its last code byte (1 to 5), each byte
// moving to the result register when it is free or being taken.
// Sustained rate, while out_ready_i is high, is one beat per cycle for decode
// and one result per cycle for encode, set by the single result register.
// Reset clears the decode accumulator and position and drops both registers.
module signed_varint_codec (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  svc_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output svc_pkg::out_t   out_data_o
);

  svc_pkg::in_t      in_q;
  logic              in_valid_q, in_valid_d;
  logic [2:0]        idx_q, idx_d;
  svc_pkg::out_t     out_q, out_d;
  logic              out_valid_q, out_valid_d;

  svc_pkg::enc_res_t enc_res;
  svc_pkg::dec_res_t dec_res;

  logic is_decode;
  logic out_free;
  logic step;
  logic finish;
  logic emit;
  logic dec_step;

  svc_encoder u_encoder (
    .value_i (in_q.data_in),
    .index_i (idx_q),
    .res_o   (enc_res)
  );

  svc_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (dec_step),
    .byte_i (in_q.data_in[7:0]),
    .res_o  (dec_res)
  );

  assign is_decode = (in_q.operation == svc_pkg::OP_DECODE);
  assign out_free  = !out_valid_q || out_ready_i;
  // a decode byte that completes nothing needs no result slot
  assign step      = in_valid_q && (out_free || (is_decode && !dec_res.done));
  assign finish    = step && (is_decode || enc_res.last);
  assign emit      = step && (!is_decode || dec_res.done);
  assign dec_step  = step && is_decode;

  assign in_ready_o = !in_valid_q || finish;

  always_comb begin
    in_valid_d = in_valid_q;
    idx_d      = idx_q;
    if (finish) begin
      in_valid_d = 1'b0;
      idx_d      = '0;
    end else if (step) begin
      idx_d = idx_q + 3'd1;
    end
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      if (is_decode) begin
        out_d.result_kind   = svc_pkg::KIND_VALUE;
        out_d.code_byte     = '0;
        out_d.decoded_value = dec_res.value;
        out_d.byte_count    = dec_res.byte_count;
        out_d.last          = 1'b1;
      end else begin
        out_d.result_kind   = svc_pkg::KIND_BYTE;
        out_d.code_byte     = enc_res.code_byte;
        out_d.decoded_value = '0;
        out_d.byte_count    = enc_res.byte_count;
        out_d.last          = enc_res.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/svc_encoder.sv]
module svc_encoder (
  input  logic [31:0]        value_i,
  input  logic [2:0]         index_i,
  output svc_pkg::enc_res_t  res_o
);

  logic [2:0] count;
  logic [6:0] payload;
  logic       is_last;

  // shortest length: bits from each field's top bit upward all equal
  always_comb begin
    if ((value_i[31:4] == '0) || (&value_i[31:4])) begin
      count = 3'd1;
    end else if ((value_i[31:11] == '0) || (&value_i[31:11])) begin
      count = 3'd2;
    end else if ((value_i[31:18] == '0) || (&value_i[31:18])) begin
      count = 3'd3;
    end else if ((value_i[31:25] == '0) || (&value_i[31:25])) begin
      count = 3'd4;
    end else begin
      count = 3'd5;
    end
  end

  assign is_last = ((index_i + 3'd1) == count);

  always_comb begin
    unique case (index_i)
      3'd0:    payload = {value_i[4:0], 2'b00};
      3'd1:    payload = value_i[11:5];
      3'd2:    payload = value_i[18:12];
      3'd3:    payload = value_i[25:19];
      default: payload = {1'b0, value_i[31:26]};
    endcase
  end

  assign res_o.code_byte  = {~is_last, payload};
  assign res_o.byte_count = count;
  assign res_o.last       = is_last;

endmodule

[hdl/svc_decoder.sv]
module svc_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  output svc_pkg::dec_res_t  res_o
);

  logic [31:0] acc_q, acc_d;
  logic [2:0]  pos_q, pos_d;
  logic [31:0] part;
  logic [31:0] gathered;
  logic [31:0] ext;
  logic        done;

  always_comb begin
    unique case (pos_q)
      3'd0: begin
        part = {27'd0, byte_i[6:2]};
        ext  = svc_pkg::EXT_MASK_1;
      end
      3'd1: begin
        part = {20'd0, byte_i[6:0], 5'd0};
        ext  = svc_pkg::EXT_MASK_2;
      end
      3'd2: begin
        part = {13'd0, byte_i[6:0], 12'd0};
        ext  = svc_pkg::EXT_MASK_3;
      end
      3'd3: begin
        part = {6'd0, byte_i[6:0], 19'd0};
        ext  = svc_pkg::EXT_MASK_4;
      end
      default: begin
        part = {byte_i[5:0], 26'd0};
        ext  = '0;
      end
    endcase
  end

  assign gathered = acc_q | part;
  assign done     = (pos_q >= 3'd4) || ((byte_i & svc_pkg::CONT_FLAG) == '0);

  assign res_o.done       = done;
  // a fifth byte gets no extension: its mask is zero
  assign res_o.value      = ((byte_i & svc_pkg::SIGN_FLAG) != '0) ? (gathered | ext) : gathered;
  assign res_o.byte_count = (pos_q >= 3'd4) ? 3'd5 : pos_q + 3'd1;

  always_comb begin
    acc_d = acc_q;
    pos_d = pos_q;
    if (step_i) begin
      if (done) begin
        acc_d = '0;
        pos_d = '0;
      end else begin
        acc_d = gathered;
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
    end else begin
      acc_q <= acc_d;
      pos_q <= pos_d;
    end
  end

endmodule

[verif/tb_top.sv]
module tb_top;
  import svc_pkg::*;

  localparam int unsigned RAND_ITEMS = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  signed_varint_codec dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  in_t codec_ops_q[$];
  out_t codec_out_q[$];

  // decode state of the model
  logic [31:0] dec_acc;
  logic [2:0] dec_pos;

  int unsigned n_items;
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_encodes;
  int unsigned n_words;
  int unsigned n_fail;
  logic in_took;

  function automatic int unsigned code_length(logic signed [31:0] v);
    if (v >= -16 && v <= 15) return 1;
    if (v >= -2048 && v <= 2047) return 2;
    if (v >= -262144 && v <= 262143) return 3;
    if (v >= -33554432 && v <= 33554431) return 4;
    return 5;
  endfunction

  task automatic model_codec_op(in_t item);
    logic [7:0] bytes[5];
    logic [7:0] b;
    logic [31:0] v;
    int unsigned n;
    out_t r;
    v = item.data_in;
    if (item.operation == OP_ENCODE) begin
      n = code_length(item.data_in);
      bytes[0] = {1'b0, v[4:0], 2'b00};
      bytes[1] = {1'b0, v[11:5]};
      bytes[2] = {1'b0, v[18:12]};
      bytes[3] = {1'b0, v[25:19]};
      bytes[4] = {2'b00, v[31:26]};
      for (int i = 0; i < n; i++) begin
        r = '0;
        r.result_kind = KIND_BYTE;
        r.code_byte = (i + 1 < n) ? (bytes[i] | CONT_FLAG) : bytes[i];
        r.byte_count = 3'(n);
        r.last = (i + 1 == n);
        codec_out_q.push_back(r);
      end
      n_encodes++;
    end else begin
      b = v[7:0];
      case (dec_pos)
        3'd0: dec_acc = {27'b0, b[6:2]};
        3'd1: dec_acc[11:5] = b[6:0];
        3'd2: dec_acc[18:12] = b[6:0];
        3'd3: dec_acc[25:19] = b[6:0];
        default: dec_acc[31:26] = b[5:0];
      endcase
      if (dec_pos < 3'd4 && (b & CONT_FLAG) != 8'h00) begin
        dec_pos++;
      end else begin
        if (dec_pos < 3'd4 && (b & SIGN_FLAG) != 8'h00) begin
          case (dec_pos)
            3'd0: dec_acc |= EXT_MASK_1;
            3'd1: dec_acc |= EXT_MASK_2;
            3'd2: dec_acc |= EXT_MASK_3;
            default: dec_acc |= EXT_MASK_4;
          endcase
        end
        r = '0;
        r.result_kind = KIND_VALUE;
        r.decoded_value = dec_acc;
        r.byte_count = dec_pos + 3'd1;
        r.last = 1'b1;
        codec_out_q.push_back(r);
        dec_acc = '0;
        dec_pos = '0;
        n_words++;
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      n_fail++;
    end
  endtask

  // input acceptance, prediction and result checking
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      in_took <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (codec_out_q.size() == 0) begin
          $error("unexpected result beat: 0x%h", out_data_o);
          n_fail++;
        end else begin
          want = codec_out_q.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_data_o.result_kind));
          check_field("code_byte", 32'(want.code_byte), 32'(out_data_o.code_byte));
          check_field("decoded_value", want.decoded_value, out_data_o.decoded_value);
          check_field("byte_count", 32'(want.byte_count), 32'(out_data_o.byte_count));
          check_field("last", 32'(want.last), 32'(out_data_o.last));
        end
      end
      if (in_valid_i && in_ready_o) begin
        model_codec_op(in_data_i);
        n_accepted++;
      end
    end else begin
      in_took <= 1'b0;
    end
  end

  // sender: bursts with random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      // hold the beat until it is taken
    end else if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      gap_left--;
    end else if (codec_ops_q.size() > 0) begin
      in_data_i <= codec_ops_q.pop_front();
      in_valid_i <= 1'b1;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver: segments of its own pattern plus one long hold-off
  int unsigned seg_left;
  int unsigned seg_mode;
  int unsigned hold_left;
  logic hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (!hold_done && n_accepted >= 60) begin
      hold_done = 1'b1;
      hold_left = 80;
      out_ready_i <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(4, 40);
      end
      seg_left--;
      case (seg_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic push_op(logic op, logic [31:0] data);
    in_t item;
    item.operation = op;
    item.data_in = data;
    codec_ops_q.push_back(item);
    n_items++;
  endtask

  task automatic push_decode_byte(logic [7:0] b);
    push_op(OP_DECODE, {24'($urandom_range(0, 32'hffffff)), b});
  endtask

  initial begin
    logic [31:0] v;
    logic [7:0] b;
    int unsigned n;
    int unsigned pick;
    dec_acc = '0;
    dec_pos = '0;
    burst_left = 0;
    gap_left = 0;
    seg_left = 0;
    seg_mode = 0;
    hold_left = 0;

    // length boundaries on both signs, including the four-byte negative edge
    push_op(OP_ENCODE, 32'sd0);
    push_op(OP_ENCODE, -32'sd1);
    push_op(OP_ENCODE, 32'sd15);
    push_op(OP_ENCODE, 32'sd16);
    push_op(OP_ENCODE, -32'sd16);
    push_op(OP_ENCODE, -32'sd17);
    push_op(OP_ENCODE, 32'sd2047);
    push_op(OP_ENCODE, 32'sd2048);
    push_op(OP_ENCODE, -32'sd2049);
    push_op(OP_ENCODE, 32'sd262144);
    push_op(OP_ENCODE, -32'sd262145);
    push_op(OP_ENCODE, 32'sd33554431);
    push_op(OP_ENCODE, -32'sd33554432);
    push_op(OP_ENCODE, -32'sd33554433);
    push_op(OP_ENCODE, 32'h7fffffff);
    push_op(OP_ENCODE, 32'h80000000);
    // one-byte word with ignored low bits set
    push_op(OP_DECODE, 32'hffffff03);
    // two-byte negative word
    push_op(OP_DECODE, 32'h000000c3);
    push_op(OP_DECODE, 32'h00000040);
    // five-byte word, an encode in the middle, fifth byte with ignored top bits
    push_op(OP_DECODE, 32'h00000080);
    push_op(OP_DECODE, 32'h00000080);
    push_op(OP_ENCODE, 32'h12345678);
    push_op(OP_DECODE, 32'h00000080);
    push_op(OP_DECODE, 32'h00000080);
    push_op(OP_DECODE, 32'h000000ff);

    while (n_items < 25 + RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        v = $urandom();
        push_op(OP_ENCODE, $signed(v) >>> $urandom_range(0, 31));
      end else if (pick < 85) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          if (i + 1 < n) b |= CONT_FLAG;
          else if (i < 4) b &= ~CONT_FLAG;
          push_decode_byte(b);
          if (i + 1 < n && $urandom_range(0, 7) == 0) push_op(OP_ENCODE, $urandom());
        end
      end else begin
        push_decode_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (n_accepted == n_items);
    wait (codec_out_q.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("covered %0d input beats (%0d encodes), %0d result beats, %0d decoded words",
             n_accepted, n_encodes, n_results, n_words);
    $display("length boundaries, interleaved encode and decode, and a long output stall");
    if (n_fail == 0 && codec_out_q.size() == 0) begin
      $display("signed_varint_codec regression: pass");
    end else begin
      $display("signed_varint_codec regression: fail");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("signed_varint_codec regression: fail");
    $finish;
  end

endmodule

[signed_varint_codec.f]
hdl/svc_pkg.sv
hdl/svc_encoder.sv
hdl/svc_decoder.sv
hdl/signed_varint_codec.sv
verif/tb_top.sv
